### rtl/core/sqs_pkg.sv
// shared types and constants for the sprite quad setup block
package sqs_pkg;

    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 56;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam int DIV_N     = 16;
    localparam int DIV_D     = 10;
    localparam int DIV_CNT_W = 4;

    localparam int TERM_W    = 3;
    localparam logic [TERM_W-1:0] TERM_LAST = 3'd4;

    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [15:0] QUARTER     = 16'h4000;

    localparam int VERT_MIN = -65536;
    localparam int VERT_MAX = 65535;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_FRAME_COLUMNS = 3'd2,
        REG_FRAME_COUNT   = 3'd3,
        REG_DRAWN_WIDTH   = 3'd4,
        REG_DRAWN_HEIGHT  = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FRAME,
        S_FRAME_WAIT,
        S_COL_WAIT,
        S_TEX_U,
        S_TEX_V,
        S_TEX_W,
        S_SIN_X,
        S_SIN_X2,
        S_SIN_LOAD,
        S_TERM_A,
        S_TERM_B,
        S_TERM_C,
        S_TERM_D,
        S_SIN_END,
        S_SIN_STORE,
        S_VPROD,
        S_SUM,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
        logic [DIV_D-1:0] remainder;
    } div_rsp_t;

    // taylor divisors, innermost term first
    function automatic logic [6:0] term_div(input logic [TERM_W-1:0] idx);
        logic [6:0] d;
        case (idx)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] term_recip(input logic [TERM_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0:    r = 32'd39045157;
            3'd1:    r = 32'd59652323;
            3'd2:    r = 32'd102261126;
            3'd3:    r = 32'd214748364;
            default: r = 32'd715827882;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/sqs_div.sv
// restoring divider, one quotient bit per cycle
module sqs_div
    import sqs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N-1:0]     quo_reg;
    logic [DIV_D-1:0]     rem_reg;
    logic [DIV_D-1:0]     dvs_reg;
    logic [DIV_D:0]       trial;
    logic [DIV_D:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_N-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_N - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_N-2:0], fits};
            rem_reg <= fits ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/core/sprite_quad_setup.sv
// sprite quad setup: frame selection, sheet coordinates and rotated corner vertices
//
// Each accepted draw transaction yields four vertex transactions in triangle fan
// order, the fourth marked by m_tlast. Work runs one transaction at a time: the
// frame reduction and the column split go through a 16-step restoring divider
// (skipped when frame_count is zero), then sine and cosine are evaluated as a
// six-term series on a single shared 32x32 multiplier, followed by four offset
// products and the corner sums; s_tready is high only between transactions.
// Configuration is to be written through cfg_we/cfg_addr/cfg_wdata only while
// the block is idle; the block itself does not enforce this.
module sprite_quad_setup
    import sqs_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // frame_index[15:0], pos_x[27:16], pos_y[39:28], angle[55:40]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // operation[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // corner[1:0], vert_x[18:2], vert_y[35:19], tex_u[45:36], tex_v[55:46]
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    localparam int ASHR   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int ASHL   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int SUM_W  = (FRAC_BITS + 45 > 49) ? FRAC_BITS + 45 : 49;
    localparam int HI_W   = SUM_W - 31;
    localparam int CX_SH  = FRAC_BITS + 31;
    localparam logic signed [HI_W-1:0]  VMIN_HI  = HI_W'(VERT_MIN);
    localparam logic signed [HI_W-1:0]  VMAX_HI  = HI_W'(VERT_MAX);
    localparam logic signed [SUM_W-1:0] RND_HALF = {{(SUM_W-31){1'b0}}, 1'b1, 30'd0};

    // configuration
    logic [9:0] frame_width_reg;
    logic [9:0] frame_height_reg;
    logic [9:0] frame_columns_reg;
    logic [9:0] frame_count_reg;
    logic [9:0] drawn_width_reg;
    logic [9:0] drawn_height_reg;

    // control
    state_t            state_reg, state_next;
    logic [9:0]        counter_reg, counter_next;
    logic              out_valid_reg, out_valid_next;
    logic              which_reg, which_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [2:0]        k_reg, k_next;
    logic [1:0]        corner_reg, corner_next;

    // payload
    logic                     op_reg, op_next;
    logic [15:0]              fi_reg, fi_next;
    logic signed [11:0]       pos_x_reg, pos_x_next;
    logic signed [11:0]       pos_y_reg, pos_y_next;
    logic [15:0]              phase_reg, phase_next;
    logic [9:0]               col_reg, col_next;
    logic [9:0]               row_reg, row_next;
    logic [9:0]               u0_reg, u0_next;
    logic [9:0]               v0_reg, v0_next;
    logic [63:0]              prod_reg, prod_next;
    logic [30:0]              x_reg, x_next;
    logic [31:0]              x2_reg, x2_next;
    logic [30:0]              t_reg, t_next;
    logic [31:0]              p_reg, p_next;
    logic [31:0]              q_reg, q_next;
    logic [30:0]              sin_mag_reg, sin_mag_next;
    logic                     sin_neg_reg, sin_neg_next;
    logic [30:0]              cos_mag_reg, cos_mag_next;
    logic                     cos_neg_reg, cos_neg_next;
    logic [40:0]              wc_reg, wc_next;
    logic [40:0]              hs_reg, hs_next;
    logic [40:0]              ws_reg, ws_next;
    logic [40:0]              hc_reg, hc_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic [M_DATA_W-1:0]      out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    // datapath helpers
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    div_req_t                div_req;
    div_rsp_t                div_rsp;
    logic [15:0]             phase_in;
    logic [15:0]             fi_abs;
    logic [9:0]              cols_eff;
    logic [9:0]              frame_sel;
    logic [9:0]              counter_adv;
    logic [14:0]             sin_idx;
    logic [31:0]             term_rem;
    logic                    term_corr;
    logic                    sx_neg;
    logic                    sy_neg;
    logic signed [SUM_W-1:0] cx;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] mag_wc;
    logic signed [SUM_W-1:0] mag_hs;
    logic signed [SUM_W-1:0] mag_ws;
    logic signed [SUM_W-1:0] mag_hc;
    logic signed [SUM_W-1:0] tx1;
    logic signed [SUM_W-1:0] tx2;
    logic signed [SUM_W-1:0] ty1;
    logic signed [SUM_W-1:0] ty2;
    logic signed [HI_W-1:0]  hi_x;
    logic signed [HI_W-1:0]  hi_y;
    logic [16:0]             vx;
    logic [16:0]             vy;
    logic [9:0]              tex_u;
    logic [9:0]              tex_v;

    sqs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign phase_in    = (s_tdata[55:40] >> ASHR) << ASHL;
    assign fi_abs      = fi_reg[15] ? (~fi_reg + 16'd1) : fi_reg;
    assign cols_eff    = (frame_columns_reg == '0) ? 10'd1 : frame_columns_reg;
    assign frame_sel   = (op_reg && fi_reg[15] && div_rsp.remainder != '0)
                         ? frame_count_reg - div_rsp.remainder : div_rsp.remainder;
    assign counter_adv = ((11'(div_rsp.remainder) + 11'd1) == 11'(frame_count_reg))
                         ? 10'd0 : div_rsp.remainder + 10'd1;
    assign sin_idx     = phase_reg[14] ? (15'h4000 - {1'b0, phase_reg[13:0]})
                                       : {1'b0, phase_reg[13:0]};
    assign term_rem    = p_reg - prod_reg[31:0];
    assign term_corr   = term_rem >= 32'(term_div(term_reg));

    // corner signs: x negative on corners 0 and 3, y negative on corners 0 and 1
    assign sx_neg = ~(corner_reg[1] ^ corner_reg[0]);
    assign sy_neg = ~corner_reg[1];

    assign cx     = SUM_W'(pos_x_reg) <<< CX_SH;
    assign cy     = SUM_W'(pos_y_reg) <<< CX_SH;
    assign mag_wc = SUM_W'(wc_reg) << FRAC_BITS;
    assign mag_hs = SUM_W'(hs_reg) << FRAC_BITS;
    assign mag_ws = SUM_W'(ws_reg) << FRAC_BITS;
    assign mag_hc = SUM_W'(hc_reg) << FRAC_BITS;
    assign tx1    = (cos_neg_reg ^ sx_neg) ? -mag_wc : mag_wc;
    assign tx2    = (sin_neg_reg ^ sy_neg) ? mag_hs : -mag_hs;
    assign ty1    = (sin_neg_reg ^ sx_neg) ? -mag_ws : mag_ws;
    assign ty2    = (cos_neg_reg ^ sy_neg) ? -mag_hc : mag_hc;

    assign hi_x = sum_x_reg[SUM_W-1:31];
    assign hi_y = sum_y_reg[SUM_W-1:31];
    assign vx   = (hi_x < VMIN_HI) ? VMIN_HI[16:0] :
                  (hi_x > VMAX_HI) ? VMAX_HI[16:0] : hi_x[16:0];
    assign vy   = (hi_y < VMIN_HI) ? VMIN_HI[16:0] :
                  (hi_y > VMAX_HI) ? VMAX_HI[16:0] : hi_y[16:0];

    assign tex_u = (corner_reg[0] ^ corner_reg[1]) ? u0_reg + frame_width_reg : u0_reg;
    assign tex_v = corner_reg[1] ? v0_reg + frame_height_reg : v0_reg;

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        out_valid_next = out_valid_reg;
        which_next     = which_reg;
        term_next      = term_reg;
        k_next         = k_reg;
        corner_next    = corner_reg;
        op_next        = op_reg;
        fi_next        = fi_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        phase_next     = phase_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        u0_next        = u0_reg;
        v0_next        = v0_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        sin_mag_next   = sin_mag_reg;
        sin_neg_next   = sin_neg_reg;
        cos_mag_next   = cos_mag_reg;
        cos_neg_next   = cos_neg_reg;
        wc_next        = wc_reg;
        hs_next        = hs_reg;
        ws_next        = ws_reg;
        hc_next        = hc_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    fi_next    = s_tdata[15:0];
                    pos_x_next = s_tdata[27:16];
                    pos_y_next = s_tdata[39:28];
                    phase_next = phase_in;
                    state_next = S_FRAME;
                end
            end
            S_FRAME:
            begin
                if (frame_count_reg == '0)
                begin
                    col_next = '0;
                    row_next = '0;
                    if (!op_reg)
                    begin
                        counter_next = '0;
                    end
                    state_next = S_TEX_U;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = op_reg ? fi_abs : 16'(counter_reg);
                    div_req.divisor  = frame_count_reg;
                    state_next       = S_FRAME_WAIT;
                end
            end
            S_FRAME_WAIT:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 16'(frame_sel);
                    div_req.divisor  = cols_eff;
                    if (!op_reg)
                    begin
                        counter_next = counter_adv;
                    end
                    state_next = S_COL_WAIT;
                end
            end
            S_COL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    col_next   = div_rsp.remainder;
                    row_next   = div_rsp.quotient[9:0];
                    state_next = S_TEX_U;
                end
            end
            S_TEX_U:
            begin
                mul_a      = 32'(col_reg);
                mul_b      = 32'(frame_width_reg);
                state_next = S_TEX_V;
            end
            S_TEX_V:
            begin
                u0_next    = prod_reg[9:0];
                mul_a      = 32'(row_reg);
                mul_b      = 32'(frame_height_reg);
                state_next = S_TEX_W;
            end
            S_TEX_W:
            begin
                v0_next    = prod_reg[9:0];
                which_next = 1'b0;
                state_next = S_SIN_X;
            end
            S_SIN_X:
            begin
                mul_a      = 32'(sin_idx);
                mul_b      = HALF_PI_Q30;
                state_next = S_SIN_X2;
            end
            S_SIN_X2:
            begin
                x_next     = prod_reg[44:14];
                mul_a      = 32'(prod_reg[44:14]);
                mul_b      = 32'(prod_reg[44:14]);
                state_next = S_SIN_LOAD;
            end
            S_SIN_LOAD:
            begin
                x2_next    = prod_reg[61:30];
                t_next     = Q30_ONE[30:0];
                term_next  = '0;
                state_next = S_TERM_A;
            end
            S_TERM_A:
            begin
                mul_a      = x2_reg;
                mul_b      = 32'(t_reg);
                state_next = S_TERM_B;
            end
            S_TERM_B:
            begin
                p_next     = prod_reg[61:30];
                mul_a      = prod_reg[61:30];
                mul_b      = term_recip(term_reg);
                state_next = S_TERM_C;
            end
            S_TERM_C:
            begin
                q_next     = prod_reg[63:32];
                mul_a      = prod_reg[63:32];
                mul_b      = 32'(term_div(term_reg));
                state_next = S_TERM_D;
            end
            S_TERM_D:
            begin
                // reciprocal estimate is at most one low
                t_next = 31'(Q30_ONE - (q_reg + 32'(term_corr)));
                if (term_reg == TERM_LAST)
                begin
                    state_next = S_SIN_END;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = S_TERM_A;
                end
            end
            S_SIN_END:
            begin
                mul_a      = 32'(x_reg);
                mul_b      = 32'(t_reg);
                state_next = S_SIN_STORE;
            end
            S_SIN_STORE:
            begin
                if (!which_reg)
                begin
                    sin_mag_next = prod_reg[60:30];
                    sin_neg_next = phase_reg[15];
                    phase_next   = phase_reg + QUARTER;
                    which_next   = 1'b1;
                    state_next   = S_SIN_X;
                end
                else
                begin
                    cos_mag_next = prod_reg[60:30];
                    cos_neg_next = phase_reg[15];
                    k_next       = '0;
                    state_next   = S_VPROD;
                end
            end
            S_VPROD:
            begin
                case (k_reg)
                    3'd1:    wc_next = prod_reg[40:0];
                    3'd2:    hs_next = prod_reg[40:0];
                    3'd3:    ws_next = prod_reg[40:0];
                    3'd4:    hc_next = prod_reg[40:0];
                    default: ;
                endcase
                case (k_reg)
                    3'd0:
                    begin
                        mul_a = 32'(drawn_width_reg);
                        mul_b = 32'(cos_mag_reg);
                    end
                    3'd1:
                    begin
                        mul_a = 32'(drawn_height_reg);
                        mul_b = 32'(sin_mag_reg);
                    end
                    3'd2:
                    begin
                        mul_a = 32'(drawn_width_reg);
                        mul_b = 32'(sin_mag_reg);
                    end
                    3'd3:
                    begin
                        mul_a = 32'(drawn_height_reg);
                        mul_b = 32'(cos_mag_reg);
                    end
                    default: ;
                endcase
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd4)
                begin
                    corner_next = '0;
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_x_next = cx + tx1 + tx2 + RND_HALF;
                sum_y_next = cy + ty1 + ty2 + RND_HALF;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {tex_v, tex_u, vy, vx, corner_reg};
                    out_last_next  = &corner_reg;
                    if (&corner_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 1'b1;
                        state_next  = S_SUM;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= 10'd32;
            frame_height_reg  <= 10'd32;
            frame_columns_reg <= 10'd1;
            frame_count_reg   <= 10'd1;
            drawn_width_reg   <= 10'd32;
            drawn_height_reg  <= 10'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata;
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata;
                REG_FRAME_COLUMNS: frame_columns_reg <= cfg_wdata;
                REG_FRAME_COUNT:   frame_count_reg   <= cfg_wdata;
                REG_DRAWN_WIDTH:   drawn_width_reg   <= cfg_wdata;
                REG_DRAWN_HEIGHT:  drawn_height_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            which_reg     <= 1'b0;
            term_reg      <= '0;
            k_reg         <= '0;
            corner_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
            which_reg     <= which_next;
            term_reg      <= term_next;
            k_reg         <= k_next;
            corner_reg    <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        fi_reg       <= fi_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        phase_reg    <= phase_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        u0_reg       <= u0_next;
        v0_reg       <= v0_next;
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        sin_mag_reg  <= sin_mag_next;
        sin_neg_reg  <= sin_neg_next;
        cos_mag_reg  <= cos_mag_next;
        cos_neg_reg  <= cos_neg_next;
        wc_reg       <= wc_next;
        hs_reg       <= hs_next;
        ws_reg       <= ws_next;
        hc_reg       <= hc_next;
        sum_x_reg    <= sum_x_next;
        sum_y_reg    <= sum_y_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

### sim/sprite_quad_setup_tb.sv
// testbench for sprite_quad_setup: directed and random draw transactions checked against a quad predictor
module sprite_quad_setup_tb
    import sqs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 4;

    localparam bit OP_NEXT_FRAME  = 1'b0;
    localparam bit OP_GIVEN_FRAME = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [16:0] vert_x;
        logic signed [16:0] vert_y;
        logic [9:0]         tex_u;
        logic [9:0]         tex_v;
        logic               last_vtx;
    } vertex_t;

    class quad_scoreboard;
        bit [9:0] frame_width   = 10'd32;
        bit [9:0] frame_height  = 10'd32;
        bit [9:0] frame_columns = 10'd1;
        bit [9:0] frame_count   = 10'd1;
        bit [9:0] drawn_width   = 10'd32;
        bit [9:0] drawn_height  = 10'd32;
        bit [9:0] frame_counter = 10'd0;
        vertex_t  pending_q[$];
        int       errors = 0;

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FRAME_WIDTH:   frame_width   = value;
                REG_FRAME_HEIGHT:  frame_height  = value;
                REG_FRAME_COLUMNS: frame_columns = value;
                REG_FRAME_COUNT:   frame_count   = value;
                REG_DRAWN_WIDTH:   drawn_width   = value;
                REG_DRAWN_HEIGHT:  drawn_height  = value;
                default: ;
            endcase
        endfunction

        // quarter-wave series sine in q30, quadrant folded
        function longint sine_q30(logic [15:0] phase);
            longint unsigned divs[5] = '{110, 72, 42, 20, 6};
            logic [63:0] idx, x, x2, t, s;
            idx = phase[14] ? 64'(17'd16384 - phase[13:0]) : 64'(phase[13:0]);
            x = (idx * 64'(HALF_PI_Q30)) >> 14;
            x2 = (x * x) >> 30;
            t = 64'(Q30_ONE);
            foreach (divs[i])
                t = 64'(Q30_ONE) - ((x2 * t) >> 30) / divs[i];
            s = (x * t) >> 30;
            return phase[15] ? -longint'(s) : longint'(s);
        endfunction

        // round halves up to FRAC_BITS fraction bits, then saturate
        function logic signed [16:0] to_vertex(longint v);
            longint r;
            r = (v + (64'sd1 <<< 30)) >>> 31;
            if (r < VERT_MIN)
                r = VERT_MIN;
            if (r > VERT_MAX)
                r = VERT_MAX;
            return r[16:0];
        endfunction

        function void note_draw(bit op, logic signed [15:0] fidx, logic signed [11:0] px,
                                logic signed [11:0] py, logic [15:0] ang);
            int unsigned cols, frame, u0, v0, uu, vv;
            int          fi_rem;
            logic [15:0] phase;
            longint      sn, cs, cx, cy, hw, hh, dx, dy, scale;
            vertex_t     vtx;
            frame = 0;
            cols = (frame_columns == 0) ? 1 : frame_columns;
            if (op == OP_GIVEN_FRAME)
            begin
                if (frame_count != 0)
                begin
                    fi_rem = int'(fidx) % int'(frame_count);
                    if (fi_rem < 0)
                        fi_rem += int'(frame_count);
                    frame = fi_rem;
                end
            end
            else if (frame_count != 0)
            begin
                frame = 32'(frame_counter % frame_count);
                frame_counter = 10'((int'(frame_counter) + 1) % int'(frame_count));
            end
            else
                frame_counter = 10'd0;

            u0 = (frame % cols) * frame_width;
            v0 = (frame / cols) * frame_height;

            if (ANGLE_BITS >= 16)
                phase = 16'(ang >> (ANGLE_BITS - 16));
            else
                phase = 16'(ang << (16 - ANGLE_BITS));
            sn = sine_q30(phase);
            cs = sine_q30(phase + QUARTER);

            scale = 64'sd1 <<< (FRAC_BITS + 31);
            cx = longint'(px) * scale;
            cy = longint'(py) * scale;
            hw = longint'(drawn_width) <<< FRAC_BITS;
            hh = longint'(drawn_height) <<< FRAC_BITS;

            for (int k = 0; k < 4; k++)
            begin
                dx = (k == 0 || k == 3) ? -hw : hw;
                dy = (k < 2) ? -hh : hh;
                uu = (k == 1 || k == 2) ? u0 + frame_width : u0;
                vv = (k >= 2) ? v0 + frame_height : v0;
                vtx.corner   = 2'(k);
                vtx.vert_x   = to_vertex(cx + dx * cs - dy * sn);
                vtx.vert_y   = to_vertex(cy + dx * sn + dy * cs);
                vtx.tex_u    = uu[9:0];
                vtx.tex_v    = vv[9:0];
                vtx.last_vtx = (k == 3);
                pending_q.push_back(vtx);
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check(logic [M_DATA_W-1:0] data, logic tlast);
            vertex_t got, want;
            got.corner   = data[1:0];
            got.vert_x   = data[18:2];
            got.vert_y   = data[35:19];
            got.tex_u    = data[45:36];
            got.tex_v    = data[55:46];
            got.last_vtx = tlast;
            if (pending_q.size() == 0)
            begin
                report($sformatf("vertex transaction with no draw pending, data %h", data));
                return;
            end
            want = pending_q.pop_front();
            if (got.corner !== want.corner)
                report($sformatf("corner %0d, expected %0d", got.corner, want.corner));
            if (got.vert_x !== want.vert_x)
                report($sformatf("corner %0d vert_x %0d, expected %0d",
                                 want.corner, got.vert_x, want.vert_x));
            if (got.vert_y !== want.vert_y)
                report($sformatf("corner %0d vert_y %0d, expected %0d",
                                 want.corner, got.vert_y, want.vert_y));
            if (got.tex_u !== want.tex_u)
                report($sformatf("corner %0d tex_u %0d, expected %0d",
                                 want.corner, got.tex_u, want.tex_u));
            if (got.tex_v !== want.tex_v)
                report($sformatf("corner %0d tex_v %0d, expected %0d",
                                 want.corner, got.tex_v, want.tex_v));
            if (got.last_vtx !== want.last_vtx)
                report($sformatf("corner %0d tlast %b, expected %b",
                                 want.corner, got.last_vtx, want.last_vtx));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;

    quad_scoreboard sb = new();

    sprite_quad_setup #(
        .ANGLE_BITS(ANGLE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
    endtask

    task automatic load_sheet(int fw, int fh, int cols, int cnt, int dw, int dh);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(fw));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(fh));
        write_reg(REG_FRAME_COLUMNS, CFG_DATA_W'(cols));
        write_reg(REG_FRAME_COUNT, CFG_DATA_W'(cnt));
        write_reg(REG_DRAWN_WIDTH, CFG_DATA_W'(dw));
        write_reg(REG_DRAWN_HEIGHT, CFG_DATA_W'(dh));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic draw(bit op, logic [15:0] fidx, logic [11:0] px, logic [11:0] py,
                        logic [15:0] ang);
        int gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ang, py, px, fidx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_draw(op, fidx, px, py, ang);
    endtask

    // hold off the sender until every vertex is back
    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_draw();
        bit          op;
        logic [15:0] fidx, ang;
        logic [11:0] px, py;
        op = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       fidx = 16'($urandom);
            1:       fidx = 16'($urandom_range(0, 80)) - 16'd20;
            2:       fidx = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: fidx = 16'($urandom_range(0, 2047));
        endcase
        px = 12'($urandom);
        py = 12'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            px = $urandom_range(0, 1) ? 12'h800 : 12'h7ff;
            py = $urandom_range(0, 1) ? 12'h800 : 12'h7ff;
        end
        ang = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            ang = 16'($urandom_range(0, 15) * 4096) + 16'($urandom_range(0, 2)) - 16'd1;
        draw(op, fidx, px, py, ang);
    endtask

    task automatic random_sheet();
        int fw, fh, cols, cnt, dw, dh;
        fw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 64);
        fh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 64);
        cols = $urandom_range(0, 12);
        case ($urandom_range(0, 9))
            0:       cnt = 0;
            1, 2:    cnt = $urandom_range(1, 1023);
            default: cnt = $urandom_range(1, 40);
        endcase
        dw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 128);
        dh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 128);
        load_sheet(fw, fh, cols, cnt, dw, dh);
    endtask

    initial
    begin : vertex_sink
        int stall;
        forever
        begin
            stall = sink_idle ? $urandom_range(0, 19) : 0;
            if (stall != 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check(m_tdata, m_tlast);
        end
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        // reset sheet: one frame, counter at zero
        draw(OP_NEXT_FRAME, 16'h0000, 12'h000, 12'h000, 16'h0000);
        draw(OP_NEXT_FRAME, 16'h1234, 12'h7ff, 12'h800, 16'h4000);
        draw(OP_GIVEN_FRAME, 16'h8000, 12'h800, 12'h800, 16'h8000);
        draw(OP_GIVEN_FRAME, 16'h7fff, 12'h7ff, 12'h7ff, 16'hc000);
        draw(OP_GIVEN_FRAME, 16'hffff, 12'h000, 12'hfff, 16'hffff);
        draw(OP_NEXT_FRAME, 16'h0000, 12'h555, 12'haaa, 16'h2000);
        wait_quiet();

        // largest sheet, texture coordinates wrap
        load_sheet(1023, 1023, 1023, 1023, 1023, 1023);
        draw(OP_GIVEN_FRAME, 16'd1022, 12'h7ff, 12'h800, 16'h2000);
        draw(OP_GIVEN_FRAME, 16'hffff, 12'h800, 12'h7ff, 16'h6000);
        draw(OP_GIVEN_FRAME, 16'h7fff, 12'h7ff, 12'h7ff, 16'ha000);
        draw(OP_NEXT_FRAME, 16'h0000, 12'h800, 12'h800, 16'he000);
        draw(OP_NEXT_FRAME, 16'h0000, 12'h123, 12'hedc, 16'h0001);
        draw(OP_NEXT_FRAME, 16'h0000, 12'hfff, 12'h001, 16'h3fff);
        wait_quiet();

        // zero frame count, zero columns and zero sizes
        load_sheet(0, 0, 0, 0, 0, 0);
        draw(OP_NEXT_FRAME, 16'h0042, 12'h010, 12'hff0, 16'h1000);
        draw(OP_GIVEN_FRAME, 16'hfffb, 12'h020, 12'h030, 16'h9000);
        wait_quiet();

        load_sheet(1, 1, 1, 1, 1, 1);
        draw(OP_GIVEN_FRAME, 16'd5, 12'h001, 12'hfff, 16'h7fff);
        draw(OP_NEXT_FRAME, 16'h0000, 12'hfff, 12'h001, 16'h8001);
        wait_quiet();

        // run the counter up, then shrink the frame count below it
        load_sheet(24, 16, 4, 1023, 100, 60);
        repeat (5)
            draw(OP_NEXT_FRAME, 16'($urandom), 12'($urandom), 12'($urandom), 16'($urandom));
        wait_quiet();
        load_sheet(24, 16, 4, 3, 100, 60);
        draw(OP_NEXT_FRAME, 16'h0000, 12'h100, 12'h0c0, 16'h0800);
        draw(OP_NEXT_FRAME, 16'h0000, 12'hf00, 12'hf40, 16'hf800);

        for (int p = 0; p < 8; p++)
        begin
            wait_quiet();
            random_sheet();
            src_idle  = (p % 4 == 0) || (p % 4 == 2);
            sink_idle = (p % 4 == 0) || (p % 4 == 3);
            for (int i = 0; i < 16; i++)
            begin
                if (i == 9 && $urandom_range(0, 2) == 0)
                    wait_quiet();
                random_draw();
            end
        end

        wait_quiet();
        repeat (120) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #8_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
